[sv/detrc_pkg.sv]
// Shared types, constants and helpers of the dual ESC throttle ramp controller.
`default_nettype none

package detrc_pkg;

	localparam int ACT_W   = 2;
	localparam int PCT_W   = 8;
	localparam int PULSE_W = 12;
	localparam int STEP_W  = 9;
	localparam int MS_W    = 16;
	localparam int PER_W   = 8;
	localparam int CNT_W   = 17;
	localparam int REG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam int DUTY_BITS_DEF = 16;
	localparam int PERIOD_US_DEF = 20000;

	// item action codes
	localparam logic [ACT_W-1:0] ACT_TICK    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_CMD     = 2'd1;
	localparam logic [ACT_W-1:0] ACT_NEUTRAL = 2'd2;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_NEUTRAL = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_FORWARD = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_REVERSE = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_STEP    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_HOLD    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_TIMEOUT = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_PERIOD  = 3'd6;

	localparam logic [PULSE_W-1:0] RST_NEUTRAL = 12'd1500;
	localparam logic [PULSE_W-1:0] RST_FORWARD = 12'd2000;
	localparam logic [PULSE_W-1:0] RST_REVERSE = 12'd1000;
	localparam logic [STEP_W-1:0]  RST_STEP    = 9'd5;
	localparam logic [MS_W-1:0]    RST_HOLD    = 16'd1500;
	localparam logic [MS_W-1:0]    RST_TIMEOUT = 16'd1000;
	localparam logic [PER_W-1:0]   RST_PERIOD  = 8'd20;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [PER_W-1:0] PER_MAX = '1;

	localparam logic signed [PCT_W-1:0] PCT_MAX = 8'sd100;
	localparam logic signed [PCT_W-1:0] PCT_MIN = -8'sd100;

	// x/100 = (x*DIV100_MUL) >> DIV100_SHIFT, exact for x below 493447
	localparam int PROD_W = 19;
	localparam int DIV100_SHIFT = 25;
	localparam int DIV100_MUL_W = 19;
	localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 19'd335545;

	// cycles the target pipeline needs after a request or register change
	localparam logic [1:0] HOLD_CYCLES = 2'd2;

	typedef struct packed {
		logic [PULSE_W-1:0] neutral;
		logic [PULSE_W-1:0] forward;
		logic [PULSE_W-1:0] reverse;
		logic [STEP_W-1:0]  step;
		logic [MS_W-1:0]    hold;
		logic [MS_W-1:0]    timeout;
		logic [PER_W-1:0]   period;
	} cfg_t;

	typedef struct packed {
		logic [PULSE_W-1:0] pulse_l;
		logic [PULSE_W-1:0] pulse_r;
		logic armed;
		logic fresh;
		logic updated;
		logic fault;
		logic by_button;
	} res_t;

	// reverse limit is tested first, so misordered limits behave as specified
	function automatic logic [PULSE_W-1:0] limit_pulse(input logic signed [PULSE_W+1:0] x,
			input logic [PULSE_W-1:0] rev, input logic [PULSE_W-1:0] fwd);
		logic [PULSE_W-1:0] r;
		if (x < $signed({2'b00, rev})) begin
			r = rev;
		end else if (x > $signed({2'b00, fwd})) begin
			r = fwd;
		end else begin
			r = x[PULSE_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[sv/detrc_if.sv]
// Valid/ready channel interfaces for throttle items and result items.
`default_nettype none

interface detrc_in_if;
	import detrc_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [ACT_W-1:0]        action;
	logic                    button_pressed;
	logic                    arm_request;
	logic signed [PCT_W-1:0] left_percent;
	logic signed [PCT_W-1:0] right_percent;

	modport source (
		output valid, action, button_pressed, arm_request, left_percent, right_percent,
		input  ready
	);
	modport sink (
		input  valid, action, button_pressed, arm_request, left_percent, right_percent,
		output ready
	);
endinterface

interface detrc_out_if #(
	parameter int DUTY_BITS = detrc_pkg::DUTY_BITS_DEF
);
	import detrc_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [PULSE_W-1:0]   left_pulse_us;
	logic [PULSE_W-1:0]   right_pulse_us;
	logic [DUTY_BITS-1:0] left_duty;
	logic [DUTY_BITS-1:0] right_duty;
	logic                 is_armed;
	logic                 command_fresh;
	logic                 control_updated;
	logic                 timeout_fault;
	logic                 button_armed;

	modport source (
		output valid, left_pulse_us, right_pulse_us, left_duty, right_duty, is_armed,
		       command_fresh, control_updated, timeout_fault, button_armed,
		input  ready
	);
	modport sink (
		input  valid, left_pulse_us, right_pulse_us, left_duty, right_duty, is_armed,
		       command_fresh, control_updated, timeout_fault, button_armed,
		output ready
	);
endinterface

`default_nettype wire

[sv/detrc_target.sv]
// Two-stage target pulse pipeline: scales one channel's request to a limited pulse.
`default_nettype none

module detrc_target (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire detrc_pkg::cfg_t                   cfg,
	input  wire logic signed [detrc_pkg::PCT_W-1:0] request,
	output logic [detrc_pkg::PULSE_W-1:0]          target
);
	import detrc_pkg::*;

	localparam int FULL_W = PROD_W + DIV100_MUL_W;

	logic                      nonneg;
	logic [PCT_W-2:0]          pct_mag;
	logic signed [PULSE_W:0]   span;
	logic [PULSE_W-1:0]        span_mag;
	logic [PROD_W-1:0]         prod_d;
	logic                      sub_d;

	logic [PROD_W-1:0]         prod_q;
	logic                      sub_q;

	logic [FULL_W-1:0]         quo_full;
	logic [PULSE_W-1:0]        quo;
	logic signed [PULSE_W+1:0] tgt_raw;
	logic [PULSE_W-1:0]        target_q;

	// stage 1: |span| * |percent|, with the sign of the final offset kept aside
	always_comb begin
		nonneg  = ~request[PCT_W-1];
		pct_mag = nonneg ? request[PCT_W-2:0] : (PCT_W-1)'(-request);
		if (nonneg) begin
			span = $signed({1'b0, cfg.forward}) - $signed({1'b0, cfg.neutral});
		end else begin
			span = $signed({1'b0, cfg.neutral}) - $signed({1'b0, cfg.reverse});
		end
		span_mag = span[PULSE_W] ? PULSE_W'(-span) : span[PULSE_W-1:0];
		prod_d   = PROD_W'(span_mag) * PROD_W'(pct_mag);
		sub_d    = span[PULSE_W] ^ request[PCT_W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_q <= '0;
			sub_q  <= 1'b0;
		end else begin
			prod_q <= prod_d;
			sub_q  <= sub_d;
		end
	end

	// stage 2: divide by 100 (truncating magnitude), offset from neutral, clamp
	always_comb begin
		quo_full = FULL_W'(prod_q) * FULL_W'(DIV100_MUL);
		quo      = quo_full[DIV100_SHIFT+PULSE_W-1:DIV100_SHIFT];
		if (sub_q) begin
			tgt_raw = $signed({2'b00, cfg.neutral}) - $signed({2'b00, quo});
		end else begin
			tgt_raw = $signed({2'b00, cfg.neutral}) + $signed({2'b00, quo});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= RST_NEUTRAL;
		end else begin
			target_q <= limit_pulse(tgt_raw, cfg.reverse, cfg.forward);
		end
	end

	assign target = target_q;

endmodule

`default_nettype wire

[sv/detrc_core.sv]
// Control state: arm button, command timeout, period counter and pulse slew.
`default_nettype none

module detrc_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire detrc_pkg::cfg_t                    cfg,
	input  wire logic                               cfg_wen,
	detrc_in_if.sink                                item,
	input  wire logic [detrc_pkg::PULSE_W-1:0]      target_l,
	input  wire logic [detrc_pkg::PULSE_W-1:0]      target_r,
	input  wire logic                               s2_free,
	output logic signed [detrc_pkg::PCT_W-1:0]      request_l,
	output logic signed [detrc_pkg::PCT_W-1:0]      request_r,
	output detrc_pkg::res_t                         res_s1,
	output logic                                    valid_s1
);
	import detrc_pkg::*;

	logic                    armed_q, armed_n;
	logic signed [PCT_W-1:0] req_l_q, req_l_n, req_r_q, req_r_n;
	logic [PULSE_W-1:0]      pulse_l_q, pulse_l_n, pulse_r_q, pulse_r_n;
	logic [CNT_W-1:0]        press_q, press_n;
	logic                    seen_q, seen_n;
	logic [CNT_W-1:0]        age_q, age_n;
	logic [PER_W-1:0]        period_q, period_n;
	logic [1:0]              hold_q;

	logic               take_in;
	logic               updated, fault, by_button, fresh_t, drive, cmd_ok;
	logic [PULSE_W-1:0] lim_neutral, tl, tr;
	res_t               res_d;

	function automatic logic [PULSE_W-1:0] slew(input logic [PULSE_W-1:0] cur,
			input logic [PULSE_W-1:0] tgt, input logic [STEP_W-1:0] step);
		logic [PULSE_W:0]          up;
		logic signed [PULSE_W+1:0] dn;
		logic [PULSE_W-1:0]        r;
		up = {1'b0, cur} + (PULSE_W+1)'(step);
		dn = $signed({2'b00, cur}) - $signed((PULSE_W+2)'(step));
		if (cur < tgt) begin
			r = (up < {1'b0, tgt}) ? up[PULSE_W-1:0] : tgt;
		end else if (cur > tgt) begin
			r = (dn > $signed({2'b00, tgt})) ? dn[PULSE_W-1:0] : tgt;
		end else begin
			r = cur;
		end
		return r;
	endfunction

	assign item.ready = (~valid_s1 | s2_free) & (hold_q == 2'd0);
	assign take_in    = item.valid & item.ready;

	assign lim_neutral = limit_pulse($signed({2'b00, cfg.neutral}), cfg.reverse, cfg.forward);

	always_comb begin
		armed_n   = armed_q;
		req_l_n   = req_l_q;
		req_r_n   = req_r_q;
		pulse_l_n = pulse_l_q;
		pulse_r_n = pulse_r_q;
		press_n   = press_q;
		seen_n    = seen_q;
		age_n     = age_q;
		period_n  = period_q;
		updated   = 1'b0;
		fault     = 1'b0;
		by_button = 1'b0;
		fresh_t   = 1'b0;
		drive     = 1'b0;
		tl        = lim_neutral;
		tr        = lim_neutral;
		cmd_ok    = (item.left_percent >= PCT_MIN) && (item.left_percent <= PCT_MAX) &&
		            (item.right_percent >= PCT_MIN) && (item.right_percent <= PCT_MAX);

		case (item.action)
			ACT_TICK: begin
				age_n    = (age_q < CNT_MAX) ? age_q + 1'b1 : age_q;
				period_n = (period_q < PER_MAX) ? period_q + 1'b1 : period_q;

				if (!item.button_pressed) begin
					press_n = '0;
				end else if (press_q == '0) begin
					press_n = CNT_W'(1);
				end else begin
					press_n = (press_q < CNT_MAX) ? press_q + 1'b1 : press_q;
					if (!armed_q && ((press_n - 1'b1) >= {1'b0, cfg.hold})) begin
						armed_n   = 1'b1;
						by_button = 1'b1;
					end
				end

				fresh_t = seen_q && (age_n <= {1'b0, cfg.timeout});
				if (armed_n && !fresh_t) begin
					armed_n = 1'b0;
					req_l_n = '0;
					req_r_n = '0;
					fault   = 1'b1;
				end

				if (period_n >= cfg.period) begin
					// target pipeline follows req_*_q; a fault-cleared request never drives
					drive     = armed_n && fresh_t;
					tl        = drive ? target_l : lim_neutral;
					tr        = drive ? target_r : lim_neutral;
					period_n  = '0;
					pulse_l_n = slew(pulse_l_q, tl, cfg.step);
					pulse_r_n = slew(pulse_r_q, tr, cfg.step);
					updated   = 1'b1;
				end
			end
			ACT_CMD: begin
				if (cmd_ok) begin
					armed_n = item.arm_request;
					req_l_n = item.arm_request ? item.left_percent : '0;
					req_r_n = item.arm_request ? item.right_percent : '0;
					seen_n  = 1'b1;
					age_n   = '0;
				end
			end
			ACT_NEUTRAL: begin
				armed_n   = 1'b0;
				req_l_n   = '0;
				req_r_n   = '0;
				pulse_l_n = cfg.neutral;
				pulse_r_n = cfg.neutral;
			end
			default: begin
			end
		endcase

		res_d.pulse_l   = pulse_l_n;
		res_d.pulse_r   = pulse_r_n;
		res_d.armed     = armed_n;
		res_d.fresh     = seen_n && (age_n <= {1'b0, cfg.timeout});
		res_d.updated   = updated;
		res_d.fault     = fault;
		res_d.by_button = by_button;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q   <= 1'b0;
			req_l_q   <= '0;
			req_r_q   <= '0;
			pulse_l_q <= RST_NEUTRAL;
			pulse_r_q <= RST_NEUTRAL;
			press_q   <= '0;
			seen_q    <= 1'b0;
			age_q     <= '0;
			period_q  <= '0;
		end else if (take_in) begin
			armed_q   <= armed_n;
			req_l_q   <= req_l_n;
			req_r_q   <= req_r_n;
			pulse_l_q <= pulse_l_n;
			pulse_r_q <= pulse_r_n;
			press_q   <= press_n;
			seen_q    <= seen_n;
			age_q     <= age_n;
			period_q  <= period_n;
		end
	end

	// requests or registers changed: let the target pipeline settle first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 2'd0;
		end else if (cfg_wen ||
				(take_in && (item.action == ACT_CMD || item.action == ACT_NEUTRAL))) begin
			hold_q <= HOLD_CYCLES;
		end else if (hold_q != 2'd0) begin
			hold_q <= hold_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (~valid_s1 | s2_free) begin
			valid_s1 <= take_in;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			res_s1 <= res_d;
		end
	end

	assign request_l = req_l_q;
	assign request_r = req_r_q;

endmodule

`default_nettype wire

[sv/detrc_duty.sv]
// Output stage: converts both pulses to PWM compare values and holds the result.
`default_nettype none

module detrc_duty #(
	parameter int DUTY_BITS = detrc_pkg::DUTY_BITS_DEF,
	parameter int PERIOD_US = detrc_pkg::PERIOD_US_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            valid_s1,
	input  wire detrc_pkg::res_t res_s1,
	output logic                 s2_free,
	detrc_out_if.source          result
);
	import detrc_pkg::*;

	// pulse*TOP/PERIOD_US by reciprocal: exact since x*err < 2^DK for all x < 2^XW
	localparam int XW = PULSE_W + DUTY_BITS;
	localparam int DK = XW + $clog2(PERIOD_US);
	localparam int MW = XW + 2;
	localparam int PW = XW + MW;
	localparam int QW = PW - DK;
	localparam int CW = QW + DUTY_BITS;
	localparam logic [MW-1:0] DMUL =
		MW'(((64'd1 << DK) + 64'(PERIOD_US) - 64'd1) / 64'(PERIOD_US));
	localparam logic [DUTY_BITS-1:0] TOP = '1;

	logic                 valid_s2;
	res_t                 res_s2;
	logic [DUTY_BITS-1:0] duty_l_s2, duty_r_s2;

	function automatic logic [DUTY_BITS-1:0] to_duty(input logic [PULSE_W-1:0] p);
		logic [XW-1:0]        scaled;
		logic [PW-1:0]        full;
		logic [QW-1:0]        quo;
		logic [DUTY_BITS-1:0] r;
		scaled = (XW'(p) << DUTY_BITS) - XW'(p);
		full   = PW'(scaled) * PW'(DMUL);
		quo    = full[PW-1:DK];
		r      = (CW'(quo) > CW'(TOP)) ? TOP : DUTY_BITS'(quo);
		return r;
	endfunction

	assign s2_free = ~valid_s2 | result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && valid_s1) begin
			res_s2    <= res_s1;
			duty_l_s2 <= to_duty(res_s1.pulse_l);
			duty_r_s2 <= to_duty(res_s1.pulse_r);
		end
	end

	assign result.valid           = valid_s2;
	assign result.left_pulse_us   = res_s2.pulse_l;
	assign result.right_pulse_us  = res_s2.pulse_r;
	assign result.left_duty       = duty_l_s2;
	assign result.right_duty      = duty_r_s2;
	assign result.is_armed        = res_s2.armed;
	assign result.command_fresh   = res_s2.fresh;
	assign result.control_updated = res_s2.updated;
	assign result.timeout_fault   = res_s2.fault;
	assign result.button_armed    = res_s2.by_button;

endmodule

`default_nettype wire

[sv/dual_esc_throttle_ramp_controller.sv]
// Dual ESC throttle controller top level: register file and block wiring.
//
// item channel: millisecond ticks (with arm button level), throttle commands and
// force-neutral events, one transfer per valid&ready edge.
// result channel: one result per item, in order: both pulses in us, both PWM
// compare values, armed and fresh state, and the event flags of the tick.
// cfg port: cfg_wen writes cfg_wdata into register cfg_index at the clock edge;
// indexes past the last register are dropped.
// A result passes the state stage, then the duty output register, before it is
// presented on the result channel.
// Throughput: one item per cycle unless held or stalled. After a command, a
// force-neutral item or a register write, the item channel stays not ready while
// the two-stage target scaler (multiply, then divide by 100) picks up the new values.
// Reset (arst_n low): disarmed, requests zero, pulses 1500 us, counters zero,
// registers back to their defaults, no result pending.
// Receiver stall: results wait in the output register; one more result waits in
// the state stage, after which the item channel stops accepting.
`default_nettype none

module dual_esc_throttle_ramp_controller #(
	parameter int DUTY_BITS = detrc_pkg::DUTY_BITS_DEF,
	parameter int PERIOD_US = detrc_pkg::PERIOD_US_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_wen,
	input  wire logic [detrc_pkg::REG_IDX_W-1:0]    cfg_index,
	input  wire logic [detrc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	detrc_in_if.sink                                item,
	detrc_out_if.source                             result
);
	import detrc_pkg::*;

	cfg_t                    cfg_q;
	logic signed [PCT_W-1:0] request_l, request_r;
	logic [PULSE_W-1:0]      target_l, target_r;
	logic                    s2_free;
	logic                    valid_s1;
	res_t                    res_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.neutral <= RST_NEUTRAL;
			cfg_q.forward <= RST_FORWARD;
			cfg_q.reverse <= RST_REVERSE;
			cfg_q.step    <= RST_STEP;
			cfg_q.hold    <= RST_HOLD;
			cfg_q.timeout <= RST_TIMEOUT;
			cfg_q.period  <= RST_PERIOD;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_NEUTRAL: cfg_q.neutral <= cfg_wdata[PULSE_W-1:0];
				REG_FORWARD: cfg_q.forward <= cfg_wdata[PULSE_W-1:0];
				REG_REVERSE: cfg_q.reverse <= cfg_wdata[PULSE_W-1:0];
				REG_STEP:    cfg_q.step    <= cfg_wdata[STEP_W-1:0];
				REG_HOLD:    cfg_q.hold    <= cfg_wdata[MS_W-1:0];
				REG_TIMEOUT: cfg_q.timeout <= cfg_wdata[MS_W-1:0];
				REG_PERIOD:  cfg_q.period  <= cfg_wdata[PER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	detrc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cfg_wen   (cfg_wen),
		.item      (item),
		.target_l  (target_l),
		.target_r  (target_r),
		.s2_free   (s2_free),
		.request_l (request_l),
		.request_r (request_r),
		.res_s1    (res_s1),
		.valid_s1  (valid_s1)
	);

	detrc_target u_target_l (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.request (request_l),
		.target  (target_l)
	);

	detrc_target u_target_r (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.request (request_r),
		.target  (target_r)
	);

	detrc_duty #(
		.DUTY_BITS (DUTY_BITS),
		.PERIOD_US (PERIOD_US)
	) u_duty (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.res_s1   (res_s1),
		.s2_free  (s2_free),
		.result   (result)
	);

endmodule

`default_nettype wire
